/* src/fblp_pkg.sv */
// Shared types, constants and the band edge table function for the band peak block.
`timescale 1ns / 1ps
`default_nettype none

package fblp_pkg;

    localparam int MAG_W        = 16;
    localparam int LEVEL_W      = 8;
    localparam int IDX_W        = 4;
    localparam int BIN_W        = 10;
    localparam int END_W        = BIN_W + 1;
    localparam int PROD_W       = MAG_W + 2 * LEVEL_W;
    localparam int ROOT_W       = PROD_W / 2;
    localparam int REM_W        = ROOT_W + 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int BIG_W        = 384;

    localparam int DEF_BAND_COUNT   = 16;
    localparam int DEF_FFT_SIZE     = 1024;
    localparam int DEF_EDGE_OCTAVES = 10;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd127;

    typedef struct packed {
        logic               last;
        logic [IDX_W-1:0]   idx;
        logic [MAG_W-1:0]   peak;
    } t_band_rec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_H,
        ST_MUL_HH,
        ST_ROOT,
        ST_SEND
    } t_back_state;

    // End bin (exclusive) of band b: largest m with m^(bands-1) <= 2^(b*oct),
    // capped at fft/2-1, and forced above the previous band's end.
    function automatic int band_end_calc(input int b, input int bands, input int fft,
                                         input int oct);
        logic [BIG_W-1:0] pw;
        logic [BIG_W-1:0] lim;
        int cap;
        int q;
        int prev;
        int lo;
        int hi;
        int mid;
        int e;
        cap  = fft / 2 - 1;
        if (cap < 1) cap = 1;
        q    = bands - 1;
        prev = 0;
        e    = 0;
        for (int i = 0; i <= b; i++) begin
            lo  = 1;
            hi  = cap;
            lim = BIG_W'(1) << (i * oct);
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                pw  = BIG_W'(1);
                for (int k = 0; k < q; k++) begin
                    pw = pw * BIG_W'(mid);
                end
                if (pw <= lim) lo = mid;
                else hi = mid - 1;
            end
            if (prev >= lo) lo = prev + 1;
            e    = lo;
            prev = lo;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

/* src/fblp_front.sv */
// Front end: takes bins, tracks bin and band counters and the running peak, posts closed bands.
`timescale 1ns / 1ps
`default_nettype none

module fblp_front #(
    parameter int BAND_COUNT   = fblp_pkg::DEF_BAND_COUNT,
    parameter int FFT_SIZE     = fblp_pkg::DEF_FFT_SIZE,
    parameter int EDGE_OCTAVES = fblp_pkg::DEF_EDGE_OCTAVES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [fblp_pkg::MAG_W-1:0]  i_magnitude,
    input  wire logic                        i_frame_start,
    input  wire logic                        i_queue_full,
    output logic                             o_push,
    output fblp_pkg::t_band_rec              o_rec
);
    import fblp_pkg::*;

    localparam int BAND_W = $clog2(BAND_COUNT + 1);
    localparam int SEL_W  = $clog2(BAND_COUNT);

    logic [END_W-1:0]   w_end [BAND_COUNT];

    for (genvar g = 0; g < BAND_COUNT; g++) begin : g_edge
        localparam int EDGE = band_end_calc(g, BAND_COUNT, FFT_SIZE, EDGE_OCTAVES);
        assign w_end[g] = END_W'(EDGE);
    end

    logic [BIN_W-1:0]   r_bin,  n_bin;
    logic [BAND_W-1:0]  r_band, n_band;
    logic [MAG_W-1:0]   r_peak, n_peak;

    logic               w_accept;
    logic               w_active;
    logic               w_close;
    logic [MAG_W-1:0]   w_max;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign w_active = r_band < BAND_W'(BAND_COUNT);
    assign w_max    = (i_magnitude > r_peak) ? i_magnitude : r_peak;
    assign w_close  = w_active &&
                      ({1'b0, r_bin} + END_W'(1) == w_end[r_band[SEL_W-1:0]]);

    assign o_push       = w_accept && !i_frame_start && w_close;
    assign o_rec.peak   = w_max;
    assign o_rec.idx    = IDX_W'(r_band);
    assign o_rec.last   = r_band == BAND_W'(BAND_COUNT - 1);

    always_comb begin
        n_bin  = r_bin;
        n_band = r_band;
        n_peak = r_peak;
        if (w_accept) begin
            if (i_frame_start) begin
                n_bin  = '0;
                n_band = '0;
                n_peak = '0;
            end else if (w_active) begin
                if (w_close) begin
                    n_band = r_band + BAND_W'(1);
                    n_peak = '0;
                end else begin
                    n_peak = w_max;
                end
                // bin counter holds at its top value on long frames
                if (r_bin != '1) n_bin = r_bin + BIN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin  <= '0;
            r_band <= '0;
            r_peak <= '0;
        end else begin
            r_bin  <= n_bin;
            r_band <= n_band;
            r_peak <= n_peak;
        end
    end

endmodule

`default_nettype wire

/* src/fblp_queue.sv */
// Small queue of closed-band records between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module fblp_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire fblp_pkg::t_band_rec    i_data,
    output logic                        o_full,
    input  wire logic                   i_pop,
    output fblp_pkg::t_band_rec         o_data,
    output logic                        o_empty
);
    import fblp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_band_rec          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic               w_push;
    logic               w_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (w_pop)  r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            if (w_push && !w_pop)      r_count <= r_count + CNT_W'(1);
            else if (w_pop && !w_push) r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

/* src/fblp_back.sv */
// Back end: scales a band peak by the height squared, takes the square root, sends the level.
`timescale 1ns / 1ps
`default_nettype none

module fblp_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [fblp_pkg::LEVEL_W-1:0]   i_cfg_data,
    input  wire logic                           i_queue_empty,
    input  wire fblp_pkg::t_band_rec            i_rec,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [fblp_pkg::LEVEL_W-1:0]        o_level,
    output logic [fblp_pkg::IDX_W-1:0]          o_idx,
    output logic                                o_last
);
    import fblp_pkg::*;

    localparam int STEP_W  = $clog2(ROOT_W);
    localparam int PROD1_W = MAG_W + LEVEL_W;

    t_back_state            r_state, n_state;
    logic [LEVEL_W-1:0]     r_height;
    logic [PROD1_W-1:0]     r_prod;
    logic [PROD_W-1:0]      r_x;
    logic [REM_W-1:0]       r_rem;
    logic [ROOT_W-1:0]      r_root;
    logic [STEP_W-1:0]      r_step;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_last;
    logic [LEVEL_W-1:0]     r_level;

    logic                   w_load;
    logic                   w_mul_h;
    logic                   w_mul_hh;
    logic                   w_root;
    logic                   w_done;
    logic                   w_root_last;
    logic [REM_W-1:0]       w_rem_sh;
    logic [REM_W-1:0]       w_trial;
    logic                   w_fit;
    logic [ROOT_W-1:0]      w_root_nx;
    logic [LEVEL_W-1:0]     w_level;

    assign w_root_last = r_step == STEP_W'(ROOT_W - 1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (!i_queue_empty) n_state = ST_MUL_H;
            ST_MUL_H:  n_state = ST_MUL_HH;
            ST_MUL_HH: n_state = ST_ROOT;
            ST_ROOT:   if (w_root_last) n_state = ST_SEND;
            ST_SEND:   if (i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_load   = 1'b0;
        w_mul_h  = 1'b0;
        w_mul_hh = 1'b0;
        w_root   = 1'b0;
        w_done   = 1'b0;
        o_valid  = 1'b0;
        unique case (r_state)
            ST_IDLE:   w_load   = !i_queue_empty;
            ST_MUL_H:  w_mul_h  = 1'b1;
            ST_MUL_HH: w_mul_hh = 1'b1;
            ST_ROOT: begin
                w_root = 1'b1;
                w_done = w_root_last;
            end
            ST_SEND:   o_valid  = 1'b1;
            default:   o_valid  = 1'b0;
        endcase
    end

    assign o_pop = w_load;

    // one result bit per cycle, two radicand bits consumed
    assign w_rem_sh  = {r_rem[REM_W-3:0], r_x[PROD_W-1 -: 2]};
    assign w_trial   = {r_root, 2'b01};
    assign w_fit     = w_rem_sh >= w_trial;
    assign w_root_nx = {r_root[ROOT_W-2:0], w_fit};
    assign w_level   = (w_root_nx[ROOT_W-1 -: LEVEL_W] > r_height) ?
                       r_height : w_root_nx[ROOT_W-1 -: LEVEL_W];

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_prod <= PROD1_W'(i_rec.peak);
            r_idx  <= i_rec.idx;
            r_last <= i_rec.last;
        end
        if (w_mul_h) r_prod <= PROD1_W'(r_prod[MAG_W-1:0]) * PROD1_W'(r_height);
        if (w_mul_hh) begin
            r_x    <= PROD_W'(r_prod) * PROD_W'(r_height);
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end
        if (w_root) begin
            r_x    <= {r_x[PROD_W-3:0], 2'b00};
            r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= w_root_nx;
            r_step <= r_step + STEP_W'(1);
        end
        if (w_done) r_level <= w_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_height <= LEVEL_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_height <= i_cfg_data;
        end
    end

    assign o_level = r_level;
    assign o_idx   = r_idx;
    assign o_last  = r_last;

endmodule

`default_nettype wire

/* src/fft_bin_log_band_peak.sv */
// Top level: log-spaced band peak levels over a stream of FFT magnitude bins.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: magnitude; tuser: frame_start
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: band_level, band_index; tlast
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_data: level_height
//
//  Bins are taken one per cycle; the front end only stalls while the two-entry
//  band queue is full. The back end takes each closed band through load, two
//  multiply steps, 16 square-root steps and send before it loads the next.
//  Synchronous active-low reset; level_height resets to 127, counters to zero.
//  A stalled m_axis holds its level; bins still flow until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module fft_bin_log_band_peak #(
    parameter int BAND_COUNT   = fblp_pkg::DEF_BAND_COUNT,
    parameter int FFT_SIZE     = fblp_pkg::DEF_FFT_SIZE,
    parameter int EDGE_OCTAVES = fblp_pkg::DEF_EDGE_OCTAVES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [15:0]    s_axis_tdata,   // [15:0] magnitude
    input  wire logic           s_axis_tuser,   // [0] frame_start
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [7:0] band_level, [11:8] band_index, pad
    output logic                m_axis_tlast,   // last_band
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [7:0]     i_cfg_data      // level_height
);
    import fblp_pkg::*;

    t_band_rec              w_push_rec;
    t_band_rec              w_head_rec;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_full;
    logic                   w_empty;
    logic [LEVEL_W-1:0]     w_level;
    logic [IDX_W-1:0]       w_idx;

    assign o_cfg_ready = 1'b1;

    fblp_front #(
        .BAND_COUNT   (BAND_COUNT),
        .FFT_SIZE     (FFT_SIZE),
        .EDGE_OCTAVES (EDGE_OCTAVES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_magnitude   (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_rec         (w_push_rec)
    );

    fblp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head_rec),
        .o_empty (w_empty)
    );

    fblp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_queue_empty (w_empty),
        .i_rec         (w_head_rec),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_level       (w_level),
        .o_idx         (w_idx),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_idx, w_level};

endmodule

`default_nettype wire

/* tb/fblp_band_checker.sv */
// Checker for the band peak block: watches the streams, predicts band levels and compares.
`timescale 1ns / 1ps

module fblp_band_checker #(
    parameter int BAND_COUNT   = fblp_pkg::DEF_BAND_COUNT,
    parameter int FFT_SIZE     = fblp_pkg::DEF_FFT_SIZE,
    parameter int EDGE_OCTAVES = fblp_pkg::DEF_EDGE_OCTAVES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    input  wire logic                         i_s_tready,
    input  wire logic [fblp_pkg::MAG_W-1:0]   i_s_tdata,   // [15:0] magnitude
    input  wire logic                         i_s_tuser,   // [0] frame_start
    input  wire logic                         i_m_tvalid,
    input  wire logic                         i_m_tready,
    input  wire logic [15:0]                  i_m_tdata,   // [7:0] level, [11:8] index, pad
    input  wire logic                         i_m_tlast,   // last_band
    input  wire logic                         i_cfg_valid,
    input  wire logic                         i_cfg_ready,
    input  wire logic [fblp_pkg::LEVEL_W-1:0] i_cfg_data,  // level_height
    output int                                o_errors,
    output int                                o_due_count
);

    localparam int LW      = fblp_pkg::LEVEL_W;
    localparam int IW      = fblp_pkg::IDX_W;
    localparam int BIN_TOP = (1 << fblp_pkg::BIN_W) - 1;

    typedef struct packed {
        logic          last;
        logic [IW-1:0] idx;
        logic [LW-1:0] level;
    } band_result_t;

    band_result_t       band_levels_due[$];
    int                 band_end [BAND_COUNT];
    int                 err_count = 0;
    logic [LW-1:0]      height;
    int                 bin_cnt;
    int                 band;
    logic [fblp_pkg::MAG_W-1:0] peak;

    assign o_errors = err_count;

    // Exclusive end bin of each band: largest m with m^(bands-1) <= 2^(b*octaves),
    // capped at fft/2-1 and pushed past the previous end.
    initial begin : build_band_ends
        logic [511:0] pw;
        int cap;
        int prev;
        int m;
        cap = FFT_SIZE / 2 - 1;
        if (cap < 1) cap = 1;
        prev = 0;
        for (int b = 0; b < BAND_COUNT; b++) begin
            m = 1;
            for (int c = 2; c <= cap; c++) begin
                pw = 512'd1;
                for (int k = 0; k < BAND_COUNT - 1; k++) pw = pw * 512'(c);
                if (pw <= (512'd1 << (b * EDGE_OCTAVES))) m = c;
            end
            if (prev >= m) m = prev + 1;
            band_end[b] = m;
            prev = m;
        end
    end

    // floor(sqrt(peak * h * h) / 256), capped at h
    function automatic logic [LW-1:0] band_level_of(input logic [15:0] pk,
                                                    input logic [LW-1:0] h);
        logic [31:0] prod;
        logic [15:0] root;
        logic [15:0] trial;
        logic [LW-1:0] lvl;
        prod = 32'(pk) * 32'(h) * 32'(h);
        root = '0;
        for (int i = 15; i >= 0; i--) begin
            trial = root | (16'd1 << i);
            if (32'(trial) * 32'(trial) <= prod) root = trial;
        end
        lvl = root[15:8];
        if (lvl > h) lvl = h;
        return lvl;
    endfunction

    always @(posedge i_clk) begin : track
        band_result_t want;
        band_result_t got;
        logic [fblp_pkg::MAG_W-1:0] mag;
        if (!i_rst_n) begin
            height  = fblp_pkg::LEVEL_RESET;
            bin_cnt = 0;
            band    = 0;
            peak    = '0;
            band_levels_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.level = i_m_tdata[LW-1:0];
                got.idx   = i_m_tdata[LW+IW-1:LW];
                got.last  = i_m_tlast;
                if (band_levels_due.size() == 0) begin
                    $display("%0t unexpected band result: level %0d idx %0d last %0b pad %h",
                             $time, got.level, got.idx, got.last, i_m_tdata[15:LW+IW]);
                    err_count++;
                end else begin
                    want = band_levels_due.pop_front();
                    if (got !== want || i_m_tdata[15:LW+IW] !== '0) begin
                        $display("%0t band mismatch: expected level %0d idx %0d last %0b pad 0,",
                                 $time, want.level, want.idx, want.last);
                        $display("%0t   got level %0d idx %0d last %0b pad %h",
                                 $time, got.level, got.idx, got.last, i_m_tdata[15:LW+IW]);
                        err_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                mag = i_s_tdata;
                if (i_s_tuser) begin
                    // DC bin: dropped, opens a new frame
                    bin_cnt = 0;
                    band    = 0;
                    peak    = '0;
                end else if (band < BAND_COUNT) begin
                    if (mag > peak) peak = mag;
                    if (bin_cnt + 1 == band_end[band]) begin
                        want.level = band_level_of(peak, height);
                        want.idx   = IW'(band);
                        want.last  = (band == BAND_COUNT - 1);
                        band_levels_due = {band_levels_due, want};
                        band++;
                        peak = '0;
                    end
                    if (bin_cnt < BIN_TOP) bin_cnt++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) height = i_cfg_data;
        end
        o_due_count <= band_levels_due.size();
    end

endmodule

/* tb/tb_fft_bin_log_band_peak.sv */
// Testbench top for the band peak block: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps

module tb_fft_bin_log_band_peak;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    int errors;
    int due_count;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;

    fft_bin_log_band_peak uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    fblp_band_checker band_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tlast   (m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_due_count (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result sink: random back-pressure plus one long hold-off on request
    initial begin : sink
        int hold_cnt;
        hold_cnt = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL fft_bin_log_band_peak");
        $finish;
    end

    function automatic logic [15:0] rand_mag();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return 16'($urandom_range(0, 255));
        if (pick < 30) return 16'hFFFF - 16'($urandom_range(0, 255));
        return 16'($urandom);
    endfunction

    task automatic send_bin(input logic [15:0] mag, input logic fs);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= mag;
        s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // DC item, then bin_total bins
    task automatic send_frame(input int bin_total);
        send_bin(rand_mag(), 1'b1);
        repeat (bin_total) send_bin(rand_mag(), 1'b0);
    endtask

    // Stop offering, wait for every due band, then let the back end settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_height(input logic [7:0] h);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= h;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int target);
        int start_cnt;
        int pick;
        start_cnt = items_sent;
        while (items_sent - start_cnt < target) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame($urandom_range(1, 120));  // cut short by the next DC item
            else
                repeat ($urandom_range(3, 12))
                    send_bin(rand_mag(), ($urandom_range(0, 7) == 0));
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        send_idle_pct = 37;
        recv_idle_pct = 57;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bins before any frame start behave like a freshly opened frame
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'h8000, 1'b0);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h1234, 1'b0);
        send_bin(16'hABCD, 1'b0);
        send_bin(16'hFFFF, 1'b1);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0000, 1'b0);
        // restart while band 2 is still open: it is dropped
        send_bin(16'h0000, 1'b1);

        write_height(8'd255);
        send_bin(16'h5A5A, 1'b1);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0001, 1'b0);
        write_height(8'd0);
        send_bin(16'hA5A5, 1'b1);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h8000, 1'b0);
        write_height(8'd1);
        send_bin(16'h0000, 1'b1);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0000, 1'b0);
        write_height(fblp_pkg::LEVEL_RESET);

        run_phase(100);

        write_height(8'($urandom_range(0, 255)));
        send_idle_pct = 57;
        recv_idle_pct = 37;
        run_phase(100);

        write_height(8'($urandom_range(0, 255)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        run_phase(100);

        drain();
        if (errors == 0)
            $display("PASS fft_bin_log_band_peak");
        else
            $display("FAIL fft_bin_log_band_peak");
        $finish;
    end

endmodule
